@@ rtl/bsu_pkg.sv @@
package bsu_pkg;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_WORD_BYTES    = 3'd0,
        CFG_SAMPLE_DEPTH  = 3'd1,
        CFG_RIGHT_ALIGNED = 3'd2,
        CFG_SAMPLE_MODE   = 3'd3,
        CFG_ZERO_GIVEN    = 3'd4,
        CFG_ZERO_VALUE    = 3'd5
    } cfg_index_t;

    // Sample interpretation modes.
    localparam logic [1:0] MODE_UNSIGNED = 2'd0;
    localparam logic [1:0] MODE_SIGNED   = 2'd1;
    localparam logic [1:0] MODE_OFFSET   = 2'd2;

    // Reset value of the word length register and the largest word length.
    localparam logic [2:0] WORD_BYTES_RESET = 3'd4;
    localparam logic [2:0] MAX_WORD_BYTES   = 3'd4;

    localparam int WORD_W = 32;
    localparam int CFG_W  = 32;

endpackage

@@ rtl/byte_to_sample_unpacker_top.sv @@
// The last byte of a word loads the word register, and the sample then moves to the result register.
// Throughput: one beat per cycle unless out_ready stalls; a word of N bytes gives one sample every N beats.
// The rate is set by the word register and the result register, each moved once per cycle.
// Reset (rst_n, asynchronous, active low) clears the word assembly and both stages and
// restores the configuration registers to their defaults: four bytes, full depth, unsigned.
module byte_to_sample_unpacker_top
    import bsu_pkg::*;
#(
    parameter int SAMPLE_BITS = 32
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_wr_en,
    input  logic [2:0]              cfg_index,
    input  logic [CFG_W-1:0]        cfg_data,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [7:0]              in_byte,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [WORD_W-1:0] sample
);

    // Configuration registers.
    logic [2:0]        word_bytes_reg;
    logic [5:0]        sample_depth_reg;
    logic              right_aligned_reg;
    logic [1:0]        sample_mode_reg;
    logic              zero_given_reg;
    logic [WORD_W-1:0] zero_value_reg;

    // Word assembly state.
    logic [1:0]  byte_index_reg;
    logic [1:0]  byte_index_next;
    logic [23:0] partial_word_reg;
    logic [23:0] partial_word_next;

    // Assembled word stage and result stage.
    logic                          word_valid_reg;
    logic [WORD_W-1:0]             word_reg;
    logic [WORD_W-1:0]             word_next;
    logic                          out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] sample_reg;
    logic signed [SAMPLE_BITS-1:0] sample_next;

    logic       in_accept;
    logic       word_advance;
    logic       word_done;
    logic [2:0] eff_bytes;
    logic [5:0] word_bits;
    logic [5:0] depth;
    logic [5:0] shift_full;
    logic [4:0] shift;
    logic [4:0] depth_m1;
    logic [WORD_W-1:0] assembled;
    logic [WORD_W-1:0] shifted;
    logic [WORD_W-1:0] offset_zero;
    logic [WORD_W-1:0] decoded;

    // Handshake: the word stage moves on when the result register is free or being taken.
    assign word_advance = !out_valid_reg || out_ready;
    assign in_ready     = !word_valid_reg || word_advance;
    assign in_accept    = in_valid && in_ready;
    assign out_valid    = out_valid_reg;
    assign sample       = WORD_W'(sample_reg);

    // Effective word length: zero and values above four mean four bytes.
    always_comb
    begin
        if (word_bytes_reg == 3'd0 || word_bytes_reg > MAX_WORD_BYTES)
        begin
            eff_bytes = MAX_WORD_BYTES;
        end
        else
        begin
            eff_bytes = word_bytes_reg;
        end
        word_bits = {eff_bytes, 3'b000};
    end

    // Byte assembly; a word is done when this byte completes the current length.
    always_comb
    begin
        word_done = ({1'b0, byte_index_reg} + 3'd1) >= eff_bytes;
        assembled = {partial_word_reg, in_byte};
        case (eff_bytes)
            3'd1:    word_next = {24'd0, assembled[7:0]};
            3'd2:    word_next = {16'd0, assembled[15:0]};
            3'd3:    word_next = {8'd0, assembled[23:0]};
            default: word_next = assembled;
        endcase
        if (word_done)
        begin
            byte_index_next   = 2'd0;
            partial_word_next = 24'd0;
        end
        else
        begin
            byte_index_next   = byte_index_reg + 2'd1;
            partial_word_next = assembled[23:0];
        end
    end

    // Depth clamp, alignment shift and zero level.
    always_comb
    begin
        if (sample_depth_reg == 6'd0 || sample_depth_reg > word_bits)
        begin
            depth = word_bits;
        end
        else
        begin
            depth = sample_depth_reg;
        end
        shift_full  = right_aligned_reg ? 6'd0 : (word_bits - depth);
        shift       = shift_full[4:0];
        depth_m1    = 5'(depth - 6'd1);
        offset_zero = zero_given_reg ? zero_value_reg : (WORD_W'(1) << depth_m1);
    end

    // Decode: arithmetic shift in signed mode, logical shift otherwise, then offset removal in offset mode.
    always_comb
    begin
        case (sample_mode_reg)
            MODE_SIGNED:
            begin
                shifted = WORD_W'($signed(word_reg) >>> shift);
                decoded = shifted;
            end
            MODE_OFFSET:
            begin
                shifted = word_reg >> shift;
                decoded = shifted - offset_zero;
            end
            default:
            begin
                shifted = word_reg >> shift;
                decoded = shifted;
            end
        endcase
        sample_next = decoded[SAMPLE_BITS-1:0];
    end

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_bytes_reg    <= WORD_BYTES_RESET;
            sample_depth_reg  <= 6'd0;
            right_aligned_reg <= 1'b0;
            sample_mode_reg   <= MODE_UNSIGNED;
            zero_given_reg    <= 1'b0;
            zero_value_reg    <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_WORD_BYTES:    word_bytes_reg    <= cfg_data[2:0];
                CFG_SAMPLE_DEPTH:  sample_depth_reg  <= cfg_data[5:0];
                CFG_RIGHT_ALIGNED: right_aligned_reg <= cfg_data[0];
                CFG_SAMPLE_MODE:   sample_mode_reg   <= cfg_data[1:0];
                CFG_ZERO_GIVEN:    zero_given_reg    <= cfg_data[0];
                CFG_ZERO_VALUE:    zero_value_reg    <= cfg_data[WORD_W-1:0];
                default:           ;
            endcase
        end
    end

    // Control state: assembly position, partial word and stage valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_index_reg   <= 2'd0;
            partial_word_reg <= 24'd0;
            word_valid_reg   <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                byte_index_reg   <= byte_index_next;
                partial_word_reg <= partial_word_next;
            end
            if (in_ready)
            begin
                word_valid_reg <= in_accept && word_done;
            end
            if (word_advance)
            begin
                out_valid_reg <= word_valid_reg;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_accept && word_done)
        begin
            word_reg <= word_next;
        end
        if (word_advance && word_valid_reg)
        begin
            sample_reg <= sample_next;
        end
    end

    // The word stage holds its beat while the result register is stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        word_valid_reg && !word_advance |=> word_valid_reg)
        else $error("assembled word lost during stall");

    // A completing byte lands in the low byte of the assembled word.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && word_done |=> word_valid_reg && word_reg[7:0] == $past(in_byte))
        else $error("completed word not captured");

    // A byte that does not finish a word advances the assembly position by one.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && !word_done |=> byte_index_reg == $past(byte_index_reg) + 2'd1)
        else $error("byte index did not advance");

    // With the word stage empty the block is always ready for a byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        !word_valid_reg |-> in_ready)
        else $error("input stalled with empty word stage");

endmodule
